// ===== hw/rtl/ps2_mouse_packet_decoder_assert.svh =====
// assertion macros for the ps2 mouse packet decoder
// included by the rtl files that check their own logic
`ifndef PS2_MOUSE_PACKET_DECODER_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_ASSERT_SVH

`ifndef SYNTH

`define PMD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

`define PMD_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`else

`define PMD_ASSERT(lbl, clk, rst_n, prop)

`define PMD_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/ps2m_pkg.sv =====
// shared types and constants of the ps2 mouse packet decoder
// no dependencies
package ps2m_pkg;

	localparam int ACCUM_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int OUT_WIDTH       = 32;
	localparam int PKT_LEN_STD     = 3;
	localparam int PKT_LEN_WHEEL   = 4;

	localparam logic [7:0] SYNC_MASK   = 8'h08;
	localparam logic [7:0] OVF_MASK    = 8'hC0;
	localparam logic [7:0] WHEEL_MASK  = 8'h0F;
	localparam logic [7:0] BUTTON_MASK = 8'h07;

	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic [1:0] POS_FLAGS = 2'd0;
	localparam logic [1:0] POS_DX    = 2'd1;
	localparam logic [1:0] POS_DY    = 2'd2;
	localparam logic [1:0] POS_WHEEL = 2'd3;

	typedef struct packed {
		logic       clr;
		logic       done;
		logic       ovf;
		logic       wen;
		logic [2:0] buttons;
		logic [7:0] dx;
		logic [7:0] dy;
		logic [3:0] wheel;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] x;
		logic signed [OUT_WIDTH-1:0] y;
		logic signed [OUT_WIDTH-1:0] w;
		logic [2:0]                  buttons;
		logic                        done;
		logic                        ovf;
	} res_t;

endpackage

// ===== hw/rtl/ps2m_fifo.sv =====
// small register queue with simultaneous push and pop
// no package dependencies; includes the assertion macro header
`include "ps2_mouse_packet_decoder_assert.svh"

module ps2m_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PMD_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`PMD_ASSERT(a_push_grows, clk, arst_n, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule

// ===== hw/rtl/ps2m_front.sv =====
// front part: packet assembly, sync check and command classification
// depends on ps2m_pkg; includes the assertion macro header
`include "ps2_mouse_packet_decoder_assert.svh"

module ps2m_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	input  logic            accept,
	input  logic            req_type,
	input  logic [7:0]      data_byte,
	input  logic            from_aux,
	output ps2m_pkg::cmd_t  cmd
);

	import ps2m_pkg::*;

	logic       wheel_mode_q;
	logic [1:0] pos_q;
	logic [1:0] pos_nxt;
	logic [7:0] byte0_q;
	logic [7:0] byte1_q;
	logic [7:0] byte2_q;
	logic [2:0] size;
	logic       take;
	logic       complete;

	assign size = wheel_mode_q ? 3'(PKT_LEN_WHEEL) : 3'(PKT_LEN_STD);
	assign take = (req_type == REQ_BYTE) && from_aux &&
		!((pos_q == POS_FLAGS) && ((data_byte & SYNC_MASK) == 8'h00));

	always_comb begin
		pos_nxt  = pos_q;
		complete = 1'b0;
		if (take) begin
			if (({1'b0, pos_q} + 3'd1) < size) begin
				pos_nxt = pos_q + 2'd1;
			end else begin
				pos_nxt  = POS_FLAGS;
				complete = 1'b1;
			end
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.clr     = (req_type == REQ_CLEAR);
		cmd.done    = complete;
		cmd.ovf     = complete && ((byte0_q & OVF_MASK) != 8'h00);
		cmd.wen     = wheel_mode_q;
		cmd.buttons = 3'(byte0_q & BUTTON_MASK);
		cmd.dx      = byte1_q;
		cmd.dy      = (pos_q == POS_DY) ? data_byte : byte2_q;
		cmd.wheel   = 4'(data_byte & WHEEL_MASK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_mode_q <= 1'b0;
			pos_q        <= POS_FLAGS;
		end else begin
			if (cfg_we) begin
				wheel_mode_q <= cfg_wdata;
			end
			if (accept) begin
				pos_q <= pos_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			case (pos_q)
				POS_FLAGS: byte0_q <= data_byte;
				POS_DX:    byte1_q <= data_byte;
				POS_DY:    byte2_q <= data_byte;
				default: begin
				end
			endcase
		end
	end

	`PMD_ASSERT(a_done_late, clk, arst_n, (accept && cmd.done) |-> (pos_q >= POS_DY))
	`PMD_NEVER(a_clr_done, clk, arst_n, accept && cmd.clr && cmd.done)

endmodule

// ===== hw/rtl/ps2m_back.sv =====
// back part: position, wheel and button accumulation
// depends on ps2m_pkg; includes the assertion macro header
`include "ps2_mouse_packet_decoder_assert.svh"

module ps2m_back #(
	parameter int ACCUM_WIDTH = ps2m_pkg::ACCUM_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  ps2m_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output ps2m_pkg::res_t res
);

	import ps2m_pkg::*;

	logic signed [ACCUM_WIDTH-1:0] x_q;
	logic signed [ACCUM_WIDTH-1:0] y_q;
	logic signed [ACCUM_WIDTH-1:0] w_q;
	logic signed [ACCUM_WIDTH-1:0] x_nxt;
	logic signed [ACCUM_WIDTH-1:0] y_nxt;
	logic signed [ACCUM_WIDTH-1:0] w_nxt;
	logic [2:0]                    buttons_q;
	logic [2:0]                    buttons_nxt;

	assign cmd_pop = cmd_valid && !res_full;

	always_comb begin
		x_nxt       = x_q;
		y_nxt       = y_q;
		w_nxt       = w_q;
		buttons_nxt = buttons_q;
		if (cmd.clr) begin
			x_nxt = '0;
			y_nxt = '0;
			w_nxt = '0;
		end else if (cmd.done) begin
			buttons_nxt = cmd.buttons;
			if (!cmd.ovf) begin
				x_nxt = x_q + ACCUM_WIDTH'(signed'(cmd.dx));
				y_nxt = y_q - ACCUM_WIDTH'(signed'(cmd.dy));
				if (cmd.wen) begin
					w_nxt = w_q + ACCUM_WIDTH'(signed'(cmd.wheel));
				end
			end
		end
	end

	always_comb begin
		res.x       = OUT_WIDTH'(x_nxt);
		res.y       = OUT_WIDTH'(y_nxt);
		res.w       = OUT_WIDTH'(w_nxt);
		res.buttons = buttons_nxt;
		res.done    = cmd.done;
		res.ovf     = cmd.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			w_q       <= '0;
			buttons_q <= '0;
		end else if (cmd_pop) begin
			x_q       <= x_nxt;
			y_q       <= y_nxt;
			w_q       <= w_nxt;
			buttons_q <= buttons_nxt;
		end
	end

	`PMD_ASSERT(a_ovf_needs_done, clk, arst_n, (cmd_pop && cmd.ovf) |-> cmd.done)
	`PMD_ASSERT(a_clear_zeroes, clk, arst_n, (cmd_pop && cmd.clr) |=> (x_q == '0 && y_q == '0 && w_q == '0))

endmodule

// ===== hw/rtl/ps2_mouse_packet_decoder.sv =====
// ps2 mouse packet decoder, top level
// depends on ps2m_pkg, ps2m_fifo, ps2m_front and ps2m_back
//
// Takes bytes from a PS/2 port as a queue (push/full) and gives one result
// item per input item, oldest first, through a queue (empty/pop). Bytes of the
// mouse channel are assembled into 3-byte packets, or 4-byte packets while
// wheel_mode is set; a leading byte without the sync bit is dropped. Each
// completed packet latches the buttons and, unless an overflow flag is set,
// moves X, Y and, while wheel_mode is set, the wheel; the positions wrap at
// ACCUM_WIDTH bits and show on 32-bit ports. A clear item zeroes the three
// positions. One item is taken every clock cycle while results are popped as
// they come. An accepted item is registered in the command queue between the
// packet assembler and the accumulate step, which writes its result into the
// result queue once that queue is not full; the result shows on the result
// ports from there. Write wheel_mode only while no items are in flight.
module ps2_mouse_packet_decoder #(
	parameter int ACCUM_WIDTH = ps2m_pkg::ACCUM_WIDTH_DEF,
	parameter int QUEUE_DEPTH = ps2m_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_wdata,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  req_type,
	input  logic [7:0]                            data_byte,
	input  logic                                  from_aux,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [ps2m_pkg::OUT_WIDTH-1:0] x_pos,
	output logic signed [ps2m_pkg::OUT_WIDTH-1:0] y_pos,
	output logic signed [ps2m_pkg::OUT_WIDTH-1:0] wheel_pos,
	output logic                                  button_left,
	output logic                                  button_right,
	output logic                                  button_middle,
	output logic                                  packet_done,
	output logic                                  packet_overflowed
);

	import ps2m_pkg::*;

	logic accept;
	cmd_t front_cmd;
	cmd_t back_cmd;
	logic cmd_empty;
	logic cmd_pop;
	res_t back_res;
	res_t out_res;
	logic res_full;

	assign accept = push && !full;

	ps2m_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.req_type  (req_type),
		.data_byte (data_byte),
		.from_aux  (from_aux),
		.cmd       (front_cmd)
	);

	ps2m_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (back_cmd),
		.empty  (cmd_empty)
	);

	ps2m_back #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res       (back_res)
	);

	ps2m_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_pop),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign x_pos             = out_res.x;
	assign y_pos             = out_res.y;
	assign wheel_pos         = out_res.w;
	assign button_left       = out_res.buttons[0];
	assign button_right      = out_res.buttons[1];
	assign button_middle     = out_res.buttons[2];
	assign packet_done       = out_res.done;
	assign packet_overflowed = out_res.ovf;

endmodule
